// ----- hw/rtl/sti_pkg.sv -----
// sti_pkg: shared constants, angle geometry and the quarter-wave sine table
// for the sine table interpolator
// no dependencies
package sti_pkg;

    localparam int ANGLE_WIDTH   = 18;
    localparam int SINE_WIDTH    = 16;
    localparam int DEG_WIDTH     = 9;
    localparam int QW_IDX_WIDTH  = 7;
    localparam int QW_ROM_DEPTH  = 91;

    localparam int QUARTER_TURN_DEG = 90;
    localparam int HALF_TURN_DEG    = 180;
    localparam int FULL_TURN_DEG    = 360;
    localparam int LAST_DEG         = 359;

    // pi in unsigned q30
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    typedef logic [SINE_WIDTH-1:0] qw_rom_t [QW_ROM_DEPTH];

    // seventh-order taylor polynomial per whole degree, evaluated at elaboration
    function automatic qw_rom_t qw_rom_build();
        qw_rom_t     rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        for (int i = 0; i < QW_ROM_DEPTH; i++) begin
            x  = (64'(i) * PI_Q30) / 64'd180;
            x2 = (x * x) >> 30;
            t  = ONE_Q30 - x2 / 64'd42;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
            s  = (x * t) >> 30;
            rom[i] = SINE_WIDTH'((s + 64'd16384) >> 15);
        end
        return rom;
    endfunction

    localparam qw_rom_t QW_ROM = qw_rom_build();

endpackage

// ----- hw/rtl/sine_table_interpolator_top.sv -----
// sine_table_interpolator_top: angle in fixed-point degrees to q1.15 sine,
// quarter-wave table lookup with linear interpolation, four register stages
// depends on sti_pkg
//
// Takes a signed angle in degrees with ANGLE_FRAC_BITS fraction bits and returns
// its sine in signed q1.15. Whole degrees come straight from a 91-entry
// quarter-wave table, mirrored past 90 degrees and negated past 180 degrees;
// fractional angles are linearly interpolated between the two neighboring whole
// degrees, rounded to nearest with ties upward, and the neighbor of 359 wraps
// to 0. Angles below 0 or at 360 degrees and above give 0 with out_of_range set.
// One angle is accepted every clock cycle unless back-pressure has filled the
// pipeline; its result passes the stages decode and fold, table read, difference
// times fraction, and the rounding add, each of them registered.
// Back-pressure on the result channel holds the pipeline in place without
// losing items.
module sine_table_interpolator_top #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [sti_pkg::ANGLE_WIDTH-1:0] s_angle,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [sti_pkg::SINE_WIDTH-1:0]  m_sine_value,
    output logic                                 m_out_of_range
);

    localparam int ANGLE_LIMIT = sti_pkg::FULL_TURN_DEG << ANGLE_FRAC_BITS;
    localparam int Y_W         = sti_pkg::SINE_WIDTH + 1;
    localparam int D_W         = Y_W + 1;
    localparam int PROD_W      = D_W + ANGLE_FRAC_BITS + 1;
    localparam int SUM_W       = PROD_W + 2;
    localparam int HALF_LSB    = 1 << (ANGLE_FRAC_BITS - 1);

    typedef struct packed {
        logic [sti_pkg::QW_IDX_WIDTH-1:0] idx;
        logic                             neg;
    } fold_t;

    // map a whole degree 0..359 onto a table index and a sign
    function automatic fold_t fold_degree(input logic [sti_pkg::DEG_WIDTH-1:0] k);
        fold_t                          r;
        logic [sti_pkg::DEG_WIDTH-1:0] kk;
        kk = k;
        r.neg = 1'b0;
        if (k <= sti_pkg::DEG_WIDTH'(sti_pkg::QUARTER_TURN_DEG)) begin
            kk = k;
        end else if (k <= sti_pkg::DEG_WIDTH'(sti_pkg::HALF_TURN_DEG)) begin
            kk = sti_pkg::DEG_WIDTH'(sti_pkg::HALF_TURN_DEG) - k;
        end else begin
            kk = k - sti_pkg::DEG_WIDTH'(sti_pkg::HALF_TURN_DEG);
            if (kk > sti_pkg::DEG_WIDTH'(sti_pkg::QUARTER_TURN_DEG)) begin
                kk = sti_pkg::DEG_WIDTH'(sti_pkg::HALF_TURN_DEG) - kk;
            end
            r.neg = 1'b1;
        end
        r.idx = kk[sti_pkg::QW_IDX_WIDTH-1:0];
        return r;
    endfunction

    // stage enables, back to front
    logic en1, en2, en3, en4;

    // stage 1: range check and fold
    logic                       v1_reg;
    fold_t                      lo1_reg, lo1_next;
    fold_t                      hi1_reg, hi1_next;
    logic [ANGLE_FRAC_BITS-1:0] f1_reg, f1_next;
    logic                       oor1_reg, oor1_next;

    // stage 2: table read
    logic                       v2_reg;
    logic signed [Y_W-1:0]      y0_2_reg, y0_2_next;
    logic signed [Y_W-1:0]      y1_2_reg, y1_2_next;
    logic [ANGLE_FRAC_BITS-1:0] f2_reg;
    logic                       oor2_reg;

    // stage 3: slope times fraction
    logic                       v3_reg;
    logic signed [Y_W-1:0]      y0_3_reg;
    logic signed [PROD_W-1:0]   prod3_reg, prod3_next;
    logic                       oor3_reg;

    // stage 4: rounding add, output word
    logic                       v4_reg;
    logic signed [sti_pkg::SINE_WIDTH-1:0] sine4_reg, sine4_next;
    logic                       oor4_reg;

    assign en4     = !v4_reg || m_ready;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    always_comb begin
        logic signed [31:0]             a_ext;
        logic signed [31:0]             k_full;
        logic [sti_pkg::DEG_WIDTH-1:0]  k0;
        logic [sti_pkg::DEG_WIDTH-1:0]  k1;
        a_ext     = 32'(s_angle);
        k_full    = a_ext >>> ANGLE_FRAC_BITS;
        k0        = k_full[sti_pkg::DEG_WIDTH-1:0];
        k1        = (k0 == sti_pkg::DEG_WIDTH'(sti_pkg::LAST_DEG)) ? '0 :
                    k0 + sti_pkg::DEG_WIDTH'(1);
        oor1_next = (a_ext < 0) || (a_ext >= ANGLE_LIMIT);
        lo1_next  = fold_degree(k0);
        hi1_next  = fold_degree(k1);
        f1_next   = s_angle[ANGLE_FRAC_BITS-1:0];
    end

    always_comb begin
        logic signed [Y_W-1:0] e0;
        logic signed [Y_W-1:0] e1;
        e0 = signed'(Y_W'(sti_pkg::QW_ROM[lo1_reg.idx]));
        e1 = signed'(Y_W'(sti_pkg::QW_ROM[hi1_reg.idx]));
        y0_2_next = lo1_reg.neg ? -e0 : e0;
        y1_2_next = hi1_reg.neg ? -e1 : e1;
    end

    always_comb begin
        logic signed [D_W-1:0]    d;
        logic signed [PROD_W-1:0] fs;
        d          = D_W'(y1_2_reg) - D_W'(y0_2_reg);
        fs         = signed'(PROD_W'(f2_reg));
        prod3_next = PROD_W'(d) * fs;
    end

    always_comb begin
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] q;
        sum = (SUM_W'(y0_3_reg) <<< ANGLE_FRAC_BITS) + SUM_W'(prod3_reg)
              + SUM_W'(HALF_LSB);
        q   = sum >>> ANGLE_FRAC_BITS;
        sine4_next = oor3_reg ? '0 : q[sti_pkg::SINE_WIDTH-1:0];
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // data path
    always_ff @(posedge aclk) begin
        if (en1) begin
            lo1_reg  <= lo1_next;
            hi1_reg  <= hi1_next;
            f1_reg   <= f1_next;
            oor1_reg <= oor1_next;
        end
        if (en2) begin
            y0_2_reg <= y0_2_next;
            y1_2_reg <= y1_2_next;
            f2_reg   <= f1_reg;
            oor2_reg <= oor1_reg;
        end
        if (en3) begin
            y0_3_reg  <= y0_2_reg;
            prod3_reg <= prod3_next;
            oor3_reg  <= oor2_reg;
        end
        if (en4) begin
            sine4_reg <= sine4_next;
            oor4_reg  <= oor3_reg;
        end
    end

    assign m_valid        = v4_reg;
    assign m_sine_value   = sine4_reg;
    assign m_out_of_range = oor4_reg;

endmodule

// ----- test/sine_table_interpolator_top_tb.sv -----
// sine_table_interpolator_top_tb: self-checking bench for the angle-to-sine block,
// random valid/ready pacing on both channels, results checked against an in-bench table
// depends on sti_pkg and sine_table_interpolator_top
module sine_table_interpolator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS    = 8;
    localparam int ONE_DEG      = 1 << FRAC_BITS;
    localparam int ANGLE_END    = sti_pkg::FULL_TURN_DEG << FRAC_BITS;
    localparam int ANGLE_MAX    = (1 << (sti_pkg::ANGLE_WIDTH - 1)) - 1;
    localparam int RANDOM_WORDS = 1400;
    localparam int TAIL_WORDS   = 120;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;

    localparam bit [63:0] PI_FIX  = 64'd3373259426;
    localparam bit [63:0] UNIT_FIX = 64'd1073741824;

    typedef logic signed [sti_pkg::ANGLE_WIDTH-1:0] angle_t;
    typedef logic signed [sti_pkg::SINE_WIDTH-1:0]  sine_t;

    typedef struct packed {
        sine_t sine;
        logic  out_of_range;
    } sine_result_t;

    logic   aclk           = 1'b0;
    logic   aresetn        = 1'b0;
    logic   s_valid        = 1'b0;
    logic   s_ready;
    angle_t s_angle        = '0;
    logic   m_valid;
    logic   m_ready        = 1'b0;
    sine_t  m_sine_value;
    logic   m_out_of_range;

    int           sine_table [sti_pkg::QW_ROM_DEPTH];
    angle_t       angle_queue [$];
    sine_result_t expected_sines [$];
    int           fail_count  = 0;
    int           cycle_count = 0;
    bit           tail_calm   = 1'b0;

    sine_table_interpolator_top #(
        .ANGLE_FRAC_BITS(FRAC_BITS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_angle       (s_angle),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sine_value  (m_sine_value),
        .m_out_of_range(m_out_of_range)
    );

    always #6 aclk = ~aclk;

    // quarter-wave entries from the taylor series in unsigned q30
    function automatic int taylor_sine_q15(int deg);
        bit [63:0] x;
        bit [63:0] x2;
        bit [63:0] t;
        bit [63:0] s;
        x  = (64'(deg) * PI_FIX) / 64'd180;
        x2 = (x * x) >> 30;
        t  = UNIT_FIX - x2 / 64'd42;
        t  = UNIT_FIX - ((x2 * t) >> 30) / 64'd20;
        t  = UNIT_FIX - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        return int'((s + 64'd16384) >> 15);
    endfunction

    function automatic int sine_at_degree(int k);
        int m;
        if (k <= sti_pkg::QUARTER_TURN_DEG) begin
            return sine_table[k];
        end
        if (k <= sti_pkg::HALF_TURN_DEG) begin
            return sine_table[sti_pkg::HALF_TURN_DEG - k];
        end
        m = k - sti_pkg::HALF_TURN_DEG;
        if (m > sti_pkg::QUARTER_TURN_DEG) begin
            m = sti_pkg::HALF_TURN_DEG - m;
        end
        return -sine_table[m];
    endfunction

    function automatic sine_result_t predict_sine(angle_t angle);
        sine_result_t r;
        int a;
        int k;
        int f;
        int y0;
        int y1;
        int num;
        a = int'(angle);
        r.out_of_range = 1'b0;
        if (a < 0 || a >= ANGLE_END) begin
            r.sine         = '0;
            r.out_of_range = 1'b1;
            return r;
        end
        k  = a >> FRAC_BITS;
        f  = a & (ONE_DEG - 1);
        y0 = sine_at_degree(k);
        if (f == 0) begin
            r.sine = sine_t'(y0);
        end else begin
            // upper neighbor of the last degree wraps to zero
            y1     = sine_at_degree(k == sti_pkg::LAST_DEG ? 0 : k + 1);
            num    = y0 * ONE_DEG + f * (y1 - y0) + (ONE_DEG >> 1);
            r.sine = sine_t'(num >>> FRAC_BITS);
        end
        return r;
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 3;
            2: return 12;
            default: return 30;
        endcase
    endfunction

    function automatic angle_t random_angle();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            return angle_t'($urandom_range(0, sti_pkg::FULL_TURN_DEG - 1) << FRAC_BITS);
        end else if (sel < 18) begin
            return angle_t'((sti_pkg::LAST_DEG << FRAC_BITS)
                            + $urandom_range(0, ONE_DEG - 1));
        end else if (sel < 80) begin
            return angle_t'($urandom_range(0, ANGLE_END - 1));
        end else if (sel < 90) begin
            return angle_t'(int'($urandom_range(0, ANGLE_MAX)) - (ANGLE_MAX + 1));
        end
        return angle_t'($urandom_range(ANGLE_END, ANGLE_MAX));
    endfunction

    // source side: one word per cycle unless an idle burst is running or s_ready is low
    int src_idle_left = 0;
    int src_idle_pct  = 0;
    int src_cycles    = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_angle <= '0;
        end else begin
            if (s_valid && s_ready) begin
                expected_sines.push_back(predict_sine(s_angle));
            end
            src_cycles++;
            if (src_cycles % 150 == 0) begin
                src_idle_pct = pick_idle_pct();
            end
            tail_calm = (angle_queue.size() < TAIL_WORDS);
            if (!s_valid || s_ready) begin
                if (src_idle_left > 0 && !tail_calm) begin
                    s_valid <= 1'b0;
                    src_idle_left--;
                end else if (angle_queue.size() > 0) begin
                    s_valid <= 1'b1;
                    s_angle <= angle_queue.pop_front();
                    if ($urandom_range(0, 99) < src_idle_pct) begin
                        src_idle_left = $urandom_range(1, 18);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // sink side: compare each result word with the oldest prediction
    int sink_stall_left = 0;
    int sink_stall_pct  = 0;
    int sink_cycles     = 0;

    always @(posedge aclk) begin
        sine_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_sines.size() == 0) begin
                $error("result word with no angle waiting: sine_value %0d out_of_range %0b",
                       m_sine_value, m_out_of_range);
                fail_count++;
            end else begin
                want = expected_sines.pop_front();
                if (m_sine_value !== want.sine) begin
                    $error("sine_value: expected %0d, got %0d", want.sine, m_sine_value);
                    fail_count++;
                end
                if (m_out_of_range !== want.out_of_range) begin
                    $error("out_of_range: expected %0b, got %0b",
                           want.out_of_range, m_out_of_range);
                    fail_count++;
                end
            end
        end
        sink_cycles++;
        if (sink_cycles % 170 == 0) begin
            sink_stall_pct = pick_idle_pct();
        end
        if (tail_calm) begin
            m_ready <= 1'b1;
        end else if (sink_stall_left > 0) begin
            m_ready <= 1'b0;
            sink_stall_left--;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 99) < sink_stall_pct) begin
                sink_stall_left = $urandom_range(1, 18);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < sti_pkg::QW_ROM_DEPTH; i++) begin
            sine_table[i] = taylor_sine_q15(i);
        end

        // field extremes, quadrant edges, wrap past the last degree, out of range
        angle_queue.push_back(angle_t'(0));
        angle_queue.push_back(angle_t'(1));
        angle_queue.push_back(angle_t'(ONE_DEG));
        angle_queue.push_back(angle_t'(45 * ONE_DEG + ONE_DEG / 4));
        angle_queue.push_back(angle_t'(89 * ONE_DEG + ONE_DEG - 1));
        angle_queue.push_back(angle_t'(sti_pkg::QUARTER_TURN_DEG * ONE_DEG));
        angle_queue.push_back(angle_t'(sti_pkg::QUARTER_TURN_DEG * ONE_DEG + ONE_DEG / 2));
        angle_queue.push_back(angle_t'(179 * ONE_DEG + ONE_DEG / 2));
        angle_queue.push_back(angle_t'(sti_pkg::HALF_TURN_DEG * ONE_DEG));
        angle_queue.push_back(angle_t'(sti_pkg::HALF_TURN_DEG * ONE_DEG + 1));
        angle_queue.push_back(angle_t'(181 * ONE_DEG + 3));
        angle_queue.push_back(angle_t'(270 * ONE_DEG));
        angle_queue.push_back(angle_t'(270 * ONE_DEG + ONE_DEG - 1));
        angle_queue.push_back(angle_t'(sti_pkg::LAST_DEG * ONE_DEG));
        angle_queue.push_back(angle_t'(sti_pkg::LAST_DEG * ONE_DEG + 1));
        angle_queue.push_back(angle_t'(sti_pkg::LAST_DEG * ONE_DEG + ONE_DEG / 2));
        angle_queue.push_back(angle_t'(ANGLE_END - 1));
        angle_queue.push_back(angle_t'(ANGLE_END));
        angle_queue.push_back(angle_t'(ANGLE_MAX));
        angle_queue.push_back(angle_t'(-1));
        angle_queue.push_back(angle_t'(-ONE_DEG));
        angle_queue.push_back(angle_t'(-(ANGLE_MAX + 1)));
        angle_queue.push_back(angle_t'(18'h15555));
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            angle_queue.push_back(random_angle());
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (angle_queue.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        while (expected_sines.size() != 0) begin
            @(posedge aclk);
        end
        // let any stray word surface before the verdict
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_sines.size() != 0) begin
            $error("%0d predicted results never arrived", expected_sines.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/sti_pkg.sv
hw/rtl/sine_table_interpolator_top.sv
test/sine_table_interpolator_top_tb.sv
